[rtl/clpm_pkg.sv]
// Types, constants and the control program of the CPU load per-mille meter.
// No dependencies; every other file imports this package.
package clpm_pkg;

  localparam int TICK_W     = 48;  // width of one tick counter field
  localparam int PERMILLE_W = 10;  // width of one per-mille result field
  localparam int CFG_W      = 16;  // width of the minimum-change register
  localparam int NUM_CTR    = 4;   // user, nice, system, idle
  localparam int PC_W       = 5;
  localparam int Q_W        = 10;  // quotient bits: a share never exceeds 1000
  localparam int CNT_W      = 4;   // holds Q_W-1

  localparam logic [PERMILLE_W-1:0] PERMILLE  = 10'd1000;
  localparam logic [CFG_W-1:0]      CFG_RESET = 16'd10;

  typedef logic [1:0]      sel_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam sel_t IDLE_SEL = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,   // take an item, form the four deltas
    OP_SUM,       // accumulate one delta into the total
    OP_SCALE,     // remainder = delta * 1000
    OP_HALF,      // remainder += total / 2, load divisor
    OP_DIV,       // one quotient bit
    OP_COMMIT,    // store counters and busy value
    OP_STALE,     // clear shares, keep busy value
    OP_EMIT       // load the output register
  } op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_SMALL,
    JC_DIV_BUSY,
    JC_OUT_FULL
  } jc_e;

  typedef struct packed {
    op_e  op;
    sel_t sel;
    jc_e  jc;
    pc_t  target;
  } uword_t;

  typedef struct packed {
    logic too_small;
    logic div_busy;
  } dp_status_t;

  typedef struct packed {
    dp_status_t dp;
    logic       in_valid;
    logic       out_full;
  } seq_status_t;

  localparam pc_t PC_WAIT  = 5'd0;
  localparam pc_t PC_STALE = 5'd19;
  localparam pc_t PC_EMIT  = 5'd20;

  function automatic uword_t uw(input op_e op, input sel_t sel, input jc_e jc,
                                input pc_t target);
    uword_t w;
    w.op     = op;
    w.sel    = sel;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = uw(OP_CAPTURE, 2'd0, JC_NO_INPUT, PC_WAIT);
      5'd1:    w = uw(OP_SUM,     2'd0, JC_NEXT,     PC_WAIT);
      5'd2:    w = uw(OP_SUM,     2'd1, JC_NEXT,     PC_WAIT);
      5'd3:    w = uw(OP_SUM,     2'd2, JC_NEXT,     PC_WAIT);
      5'd4:    w = uw(OP_SUM,     2'd3, JC_NEXT,     PC_WAIT);
      5'd5:    w = uw(OP_NOP,     2'd0, JC_SMALL,    PC_STALE);
      5'd6:    w = uw(OP_SCALE,   2'd0, JC_NEXT,     PC_WAIT);
      5'd7:    w = uw(OP_HALF,    2'd0, JC_NEXT,     PC_WAIT);
      5'd8:    w = uw(OP_DIV,     2'd0, JC_DIV_BUSY, 5'd8);
      5'd9:    w = uw(OP_SCALE,   2'd1, JC_NEXT,     PC_WAIT);
      5'd10:   w = uw(OP_HALF,    2'd1, JC_NEXT,     PC_WAIT);
      5'd11:   w = uw(OP_DIV,     2'd1, JC_DIV_BUSY, 5'd11);
      5'd12:   w = uw(OP_SCALE,   2'd2, JC_NEXT,     PC_WAIT);
      5'd13:   w = uw(OP_HALF,    2'd2, JC_NEXT,     PC_WAIT);
      5'd14:   w = uw(OP_DIV,     2'd2, JC_DIV_BUSY, 5'd14);
      5'd15:   w = uw(OP_SCALE,   2'd3, JC_NEXT,     PC_WAIT);
      5'd16:   w = uw(OP_HALF,    2'd3, JC_NEXT,     PC_WAIT);
      5'd17:   w = uw(OP_DIV,     2'd3, JC_DIV_BUSY, 5'd17);
      5'd18:   w = uw(OP_COMMIT,  2'd0, JC_ALWAYS,   PC_EMIT);
      5'd19:   w = uw(OP_STALE,   2'd0, JC_NEXT,     PC_WAIT);
      5'd20:   w = uw(OP_EMIT,    2'd0, JC_OUT_FULL, PC_EMIT);
      default: w = uw(OP_NOP,     2'd0, JC_ALWAYS,   PC_WAIT);
    endcase
    return w;
  endfunction

endpackage

[rtl/clpm_if.sv]
// Valid/ready channel interfaces of the CPU load per-mille meter.
// Depends on clpm_pkg for the field widths.
interface clpm_tick_if import clpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] user_ticks;
  logic [TICK_W-1:0] nice_ticks;
  logic [TICK_W-1:0] system_ticks;
  logic [TICK_W-1:0] idle_ticks;

  modport source (output valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                  input ready);
  modport sink   (input valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                  output ready);
endinterface

interface clpm_load_if import clpm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PERMILLE_W-1:0] user_permille;
  logic [PERMILLE_W-1:0] nice_permille;
  logic [PERMILLE_W-1:0] system_permille;
  logic [PERMILLE_W-1:0] idle_permille;
  logic [PERMILLE_W-1:0] busy_permille;
  logic                  fresh;

  modport source (output valid, user_permille, nice_permille, system_permille,
                  idle_permille, busy_permille, fresh, input ready);
  modport sink   (input valid, user_permille, nice_permille, system_permille,
                  idle_permille, busy_permille, fresh, output ready);
endinterface

interface clpm_cfg_if import clpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/cpu_load_permille_meter_top.sv]
// Top level of the CPU load per-mille meter: config register, output register,
// sequencer and datapath. Depends on clpm_pkg, clpm_if, clpm_seq and clpm_dp.
//
// Usage
//   tick_i : one item per sample, four cumulative tick counters (user, nice,
//            system, idle). Only the low COUNTER_BITS bits of each are used.
//   load_o : one item per input item: four rounded shares in per mille, busy
//            (1000 minus idle share) and a fresh flag.
//   cfg_i  : writes min_total_change; always ready. Write only while idle.
//   Deltas are taken modulo 2^COUNTER_BITS. When their sum is zero or below
//   min_total_change the shares read zero, fresh is low, busy repeats the last
//   fresh value and the stored counters are left alone.
// Flow
//   A fresh item is summed and each share scaled and divided in turn in one
//   restoring divider, ten quotient bits each; a stale one goes from the sum
//   check to the stale step. tick_i.ready is high only while the sequencer
//   waits at its first step, so the next item waits until the last is emitted.
// Reset and stall
//   Reset clears the stored counters and busy value and loads 10 into
//   min_total_change. A held result sits in the output register; the next
//   item is still taken and worked on, and the sequencer waits at its emit
//   step until the receiver has taken the earlier result.
module cpu_load_permille_meter_top import clpm_pkg::*; #(
  parameter int COUNTER_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clpm_cfg_if.sink      cfg_i,
  clpm_tick_if.sink     tick_i,
  clpm_load_if.source   load_o
);

  logic [CFG_W-1:0]                   min_total_q;
  uword_t                             ctrl;
  seq_status_t                        seq_status;
  dp_status_t                         dp_status;
  logic                               in_fire;
  logic                               out_full;
  logic                               emit;
  logic [NUM_CTR-1:0][TICK_W-1:0]     ticks;
  logic [NUM_CTR-1:0][PERMILLE_W-1:0] share;
  logic [NUM_CTR-1:0][PERMILLE_W-1:0] out_share_q;
  logic [PERMILLE_W-1:0]              busy, out_busy_q;
  logic                               fresh, out_fresh_q;
  logic                               out_valid_q, out_valid_d;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_total_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      min_total_q <= cfg_i.data;
    end
  end

  // Input side: index 0 user, 1 nice, 2 system, 3 idle
  assign ticks        = {tick_i.idle_ticks, tick_i.system_ticks,
                         tick_i.nice_ticks, tick_i.user_ticks};
  assign tick_i.ready = (ctrl.op == OP_CAPTURE);
  assign in_fire      = tick_i.valid && tick_i.ready;

  // Output register; a new result may load in the cycle the old one leaves
  assign out_full = out_valid_q && !load_o.ready;
  assign emit     = (ctrl.op == OP_EMIT) && !out_full;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_share_q <= share;
      out_busy_q  <= busy;
      out_fresh_q <= fresh;
    end
  end

  assign load_o.valid           = out_valid_q;
  assign load_o.user_permille   = out_share_q[0];
  assign load_o.nice_permille   = out_share_q[1];
  assign load_o.system_permille = out_share_q[2];
  assign load_o.idle_permille   = out_share_q[3];
  assign load_o.busy_permille   = out_busy_q;
  assign load_o.fresh           = out_fresh_q;

  // Sequencer and datapath
  assign seq_status.dp       = dp_status;
  assign seq_status.in_valid = tick_i.valid;
  assign seq_status.out_full = out_full;

  clpm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (seq_status),
    .ctrl_o   (ctrl)
  );

  clpm_dp #(
    .CounterBits (COUNTER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_fire_i   (in_fire),
    .ticks_i     (ticks),
    .min_total_i (min_total_q),
    .status_o    (dp_status),
    .share_o     (share),
    .busy_o      (busy),
    .fresh_o     (fresh)
  );

  // Checks
  a_busy_idle_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o.valid && load_o.fresh |->
      ({1'b0, load_o.busy_permille} + {1'b0, load_o.idle_permille}) ==
      (PERMILLE_W + 1)'(PERMILLE))
    else $error("busy and idle shares do not add up to 1000");

  a_stale_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o.valid && !load_o.fresh |->
      load_o.user_permille == '0 && load_o.nice_permille == '0 &&
      load_o.system_permille == '0 && load_o.idle_permille == '0)
    else $error("stale result carries non-zero shares");

  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o.valid |->
      load_o.user_permille <= PERMILLE && load_o.nice_permille <= PERMILLE &&
      load_o.system_permille <= PERMILLE && load_o.idle_permille <= PERMILLE)
    else $error("share above 1000");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !tick_i.ready)
    else $error("item taken while the previous one is in progress");

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !load_o.ready |=> $stable(out_busy_q) && $stable(out_fresh_q))
    else $error("held result overwritten");

endmodule

[rtl/clpm_seq.sv]
// Microcode sequencer: step counter, control store and jump logic.
// Depends on clpm_pkg for the control word and the program.
module clpm_seq import clpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output uword_t      ctrl_o
);

  pc_t    pc_q, pc_d;
  uword_t word;
  logic   take;

  assign word   = ucode_rom(pc_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.jc)
      JC_NEXT:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NO_INPUT: take = !status_i.in_valid;
      JC_SMALL:    take = status_i.dp.too_small;
      JC_DIV_BUSY: take = status_i.dp.div_busy;
      JC_OUT_FULL: take = status_i.out_full;
      default:     take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[rtl/clpm_dp.sv]
// Datapath: counter deltas, total, shared restoring divider and result registers.
// Depends on clpm_pkg; driven by the control word from clpm_seq.
module clpm_dp import clpm_pkg::*; #(
  parameter int CounterBits = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  uword_t                                ctrl_i,
  input  logic                                  in_fire_i,
  input  logic [NUM_CTR-1:0][TICK_W-1:0]        ticks_i,
  input  logic [CFG_W-1:0]                      min_total_i,
  output dp_status_t                            status_o,
  output logic [NUM_CTR-1:0][PERMILLE_W-1:0]    share_o,
  output logic [PERMILLE_W-1:0]                 busy_o,
  output logic                                  fresh_o
);

  localparam int WideW = (CounterBits > TICK_W) ? CounterBits : TICK_W;
  localparam int TotW  = CounterBits + 2;
  localparam int RemW  = CounterBits + 12;

  logic [NUM_CTR-1:0][CounterBits-1:0] prev_q, prev_d, delta_q, delta_d;
  logic [NUM_CTR-1:0][PERMILLE_W-1:0]  share_q, share_d;
  logic [TotW-1:0]                     total_q, total_d;
  logic [RemW-1:0]                     rem_q, rem_d, dsr_q, dsr_d, dx;
  logic [Q_W-1:0]                      quo_q, quo_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic [PERMILLE_W-1:0]               busy_q, busy_d;
  logic                                fresh_q, fresh_d;
  logic                                ge;
  logic [NUM_CTR-1:0][WideW-1:0]       ext;

  for (genvar i = 0; i < NUM_CTR; i++) begin : g_ext
    assign ext[i] = WideW'(ticks_i[i]);
  end

  assign dx = RemW'(delta_q[ctrl_i.sel]);
  assign ge = rem_q >= dsr_q;

  always_comb begin
    prev_d  = prev_q;
    delta_d = delta_q;
    share_d = share_q;
    total_d = total_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    fresh_d = fresh_q;
    unique case (ctrl_i.op)
      OP_CAPTURE: begin
        if (in_fire_i) begin
          for (int i = 0; i < NUM_CTR; i++) begin
            delta_d[i] = ext[i][CounterBits-1:0] - prev_q[i];
          end
        end
      end
      OP_SUM: begin
        total_d = ((ctrl_i.sel == 2'd0) ? '0 : total_q) + TotW'(delta_q[ctrl_i.sel]);
      end
      OP_SCALE: begin
        // 1000 = 1024 - 16 - 8
        rem_d = (dx << 10) - (dx << 4) - (dx << 3);
      end
      OP_HALF: begin
        rem_d = rem_q + RemW'(total_q >> 1);
        dsr_d = RemW'(total_q) << (Q_W - 1);
        quo_d = '0;
        cnt_d = CNT_W'(Q_W - 1);
      end
      OP_DIV: begin
        rem_d = ge ? rem_q - dsr_q : rem_q;
        dsr_d = dsr_q >> 1;
        quo_d = {quo_q[Q_W-2:0], ge};
        if (cnt_q == '0) begin
          share_d[ctrl_i.sel] = PERMILLE_W'({quo_q[Q_W-2:0], ge});
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      OP_COMMIT: begin
        for (int i = 0; i < NUM_CTR; i++) begin
          prev_d[i] = prev_q[i] + delta_q[i];
        end
        busy_d  = PERMILLE - share_q[IDLE_SEL];
        fresh_d = 1'b1;
      end
      OP_STALE: begin
        share_d = '0;
        fresh_d = 1'b0;
      end
      OP_NOP, OP_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      busy_q  <= '0;
      cnt_q   <= '0;
      fresh_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    share_q <= share_d;
    total_q <= total_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    quo_q   <= quo_d;
  end

  assign status_o.too_small = (total_q == '0) || (total_q < TotW'(min_total_i));
  assign status_o.div_busy  = (cnt_q != '0);
  assign share_o            = share_q;
  assign busy_o             = busy_q;
  assign fresh_o            = fresh_q;

endmodule
